// ----- hdl/rbtl_pkg.sv -----
package rbtl_pkg;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        REG_INDEX_SCALE  = 3'd0,
        REG_LOWER_TABLE  = 3'd1,
        REG_UPPER_TABLE  = 3'd2,
        REG_BLEND_WEIGHT = 3'd3,
        REG_FLOOR_LEVEL  = 3'd4
    } reg_index_t;

    typedef struct packed
    {
        logic signed [19:0] beam_value;
        logic               beyond_edge;
    } result_t;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [15:0] FLOOR_RESET = 16'd7;
    localparam int          OUT_DEPTH   = 8;

endpackage

// ----- hdl/rbtl_ram.sv -----
module rbtl_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // read-first: a read at the same edge as a write returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- hdl/rbtl_out_fifo.sv -----
module rbtl_out_fifo #(
    parameter int DEPTH = 8,
    localparam int PW = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rbtl_pkg::result_t push_data,
    input  logic              pop,
    output logic              valid,
    output rbtl_pkg::result_t data
);
    import rbtl_pkg::*;

    result_t         entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;
    logic            do_pop;

    assign valid  = (count_reg != '0);
    assign data   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/radial_beam_table_lookup_unit.sv -----
// A query result passes radius scaling, table read, two blend products, their sum, floor scaling
// and rounding, then the result queue, before it shows on m_tvalid.
// Throughput: one item per cycle while s_tready is high; both table reads use the two read ports of one RAM.
// Up to OUT_DEPTH query results may be in flight or queued; s_tready drops when all are taken.
// Reset: rst_n clears control state and the registers (floor_level to 7, others to 0);
// table contents are undefined until written, and no clearing pass runs.
module radial_beam_table_lookup_unit #(
    parameter int SAMPLES    = 1024,
    parameter int TABLES     = 8,
    parameter int VALUE_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] table_number, [12:3] sample_number, [32:13] entry_value,
    // [57:33] radius, [63:58] zero
    input  logic [63:0] s_tdata,
    // [0] opcode, [1] radius_invalid
    input  logic [1:0]  s_tuser,
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    // [19:0] beam_value, [23:20] zero
    output logic [23:0] m_tdata,
    // [0] beyond_edge
    output logic [0:0]  m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbtl_pkg::*;

    localparam int SB    = $clog2(SAMPLES);
    localparam int TB    = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int DEPTH = TABLES * (2 ** SB);
    localparam int AW    = $clog2(DEPTH);
    localparam int VB    = VALUE_BITS;
    localparam int BW    = VB + 18;
    localparam int HW    = BW - 24;
    localparam int PHW   = HW + 18;
    localparam int TW    = VB + 37;
    localparam int QW    = TW - 32;
    localparam int OB    = (VB < 20) ? VB : 20;
    localparam int CW    = $clog2(OUT_DEPTH + 1);

    localparam logic signed [32:0] EMAX = 33'((64'sd1 <<< (VB - 1)) - 64'sd1);
    localparam logic signed [32:0] EMIN = -EMAX - 33'sd1;
    localparam logic signed [QW-1:0] OMAX = QW'((64'sd1 <<< (OB - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] OMIN = -OMAX - QW'(1);

    // input fields
    logic               in_opcode;
    logic               in_radius_invalid;
    logic [2:0]         in_table_number;
    logic [9:0]         in_sample_number;
    logic signed [19:0] in_entry_value;
    logic [24:0]        in_radius;

    assign in_opcode         = s_tuser[0];
    assign in_radius_invalid = s_tuser[1];
    assign in_table_number   = s_tdata[2:0];
    assign in_sample_number  = s_tdata[12:3];
    assign in_entry_value    = s_tdata[32:13];
    assign in_radius         = s_tdata[57:33];

    // configuration registers
    logic [31:0] index_scale_reg;
    logic [2:0]  lower_table_reg;
    logic [2:0]  upper_table_reg;
    logic [16:0] blend_weight_reg;
    logic [15:0] floor_level_reg;
    logic        cfg_wr;
    reg_index_t  cfg_index;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_scale_reg  <= '0;
            lower_table_reg  <= '0;
            upper_table_reg  <= '0;
            blend_weight_reg <= '0;
            floor_level_reg  <= FLOOR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_INDEX_SCALE:  index_scale_reg  <= pwdata;
                REG_LOWER_TABLE:  lower_table_reg  <= pwdata[2:0];
                REG_UPPER_TABLE:  upper_table_reg  <= pwdata[2:0];
                REG_BLEND_WEIGHT: blend_weight_reg <= pwdata[16:0];
                REG_FLOOR_LEVEL:  floor_level_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_INDEX_SCALE:  prdata = index_scale_reg;
            REG_LOWER_TABLE:  prdata = 32'(lower_table_reg);
            REG_UPPER_TABLE:  prdata = 32'(upper_table_reg);
            REG_BLEND_WEIGHT: prdata = 32'(blend_weight_reg);
            REG_FLOOR_LEVEL:  prdata = 32'(floor_level_reg);
            default:          prdata = '0;
        endcase
    end

    // input handshake and result credits
    logic          in_acc;
    logic          query_acc;
    logic          out_acc;
    logic [CW-1:0] outstanding_reg;
    logic [CW-1:0] outstanding_next;

    assign s_tready  = (32'(outstanding_reg) < OUT_DEPTH);
    assign in_acc    = s_tvalid && s_tready;
    assign query_acc = in_acc && (opcode_t'(in_opcode) == OP_QUERY);
    assign out_acc   = m_tvalid && m_tready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (query_acc && !out_acc)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (!query_acc && out_acc)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    // table write: commits at the accepting edge, ahead of any later query read
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [32:0]   entry_ext;
    logic signed [32:0]   entry_sat;
    logic [VB-1:0]        wr_data;

    assign entry_ext = 33'(in_entry_value);
    assign entry_sat = (entry_ext > EMAX) ? EMAX : ((entry_ext < EMIN) ? EMIN : entry_ext);
    assign wr_data   = VB'(entry_sat);
    assign wr_addr   = AW'({TB'(in_table_number), SB'(in_sample_number)});
    assign wr_en     = in_acc && (opcode_t'(in_opcode) == OP_WRITE)
                       && (32'(in_table_number) < TABLES)
                       && (32'(in_sample_number) < SAMPLES);

    // stage 1: scaled index
    logic [56:0] index_product;
    logic        q1_valid_reg;
    logic [24:0] q1_index_reg;
    logic        q1_invalid_reg;
    logic        q1_in_range;
    logic        lower_ok;
    logic        upper_ok;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;

    assign index_product = 57'(in_radius) * 57'(index_scale_reg);
    assign q1_in_range   = !q1_invalid_reg && (32'(q1_index_reg) < SAMPLES);
    assign lower_ok      = (32'(lower_table_reg) < TABLES);
    assign upper_ok      = (32'(upper_table_reg) < TABLES);
    assign rd_addr_a     = AW'({TB'(lower_table_reg), SB'(q1_index_reg)});
    assign rd_addr_b     = AW'({TB'(upper_table_reg), SB'(q1_index_reg)});

    logic [VB-1:0] rdata_a;
    logic [VB-1:0] rdata_b;

    rbtl_ram #(
        .WIDTH (VB),
        .DEPTH (DEPTH)
    ) u_tables (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // stage 2: table words, blend products
    logic                q2_valid_reg;
    logic                q2_in_range_reg;
    logic                q2_lower_ok_reg;
    logic                q2_upper_ok_reg;
    logic signed [VB-1:0] entry_a;
    logic signed [VB-1:0] entry_b;
    logic [16:0]         weight_upper;
    logic [16:0]         weight_lower;
    logic signed [BW-1:0] prod_a;
    logic signed [BW-1:0] prod_b;

    assign entry_a      = q2_lower_ok_reg ? $signed(rdata_a) : '0;
    assign entry_b      = q2_upper_ok_reg ? $signed(rdata_b) : '0;
    assign weight_upper = (blend_weight_reg > ONE_Q16) ? ONE_Q16 : blend_weight_reg;
    assign weight_lower = ONE_Q16 - weight_upper;
    assign prod_a       = entry_a * $signed({1'b0, weight_lower});
    assign prod_b       = entry_b * $signed({1'b0, weight_upper});

    // stage 3: sum of products
    logic                 q3_valid_reg;
    logic                 q3_in_range_reg;
    logic signed [BW-1:0] q3_pa_reg;
    logic signed [BW-1:0] q3_pb_reg;

    // stage 4: blended value, split for the floor scaling
    logic                  q4_valid_reg;
    logic                  q4_in_range_reg;
    logic signed [BW-1:0]  q4_blend_reg;
    logic [16:0]           floor_gain;
    logic [40:0]           part_lo;
    logic signed [PHW-1:0] part_hi;

    assign floor_gain = ONE_Q16 - 17'(floor_level_reg);
    assign part_lo    = 41'(q4_blend_reg[23:0]) * 41'(floor_gain);
    assign part_hi    = $signed(q4_blend_reg[BW-1:24]) * $signed({1'b0, floor_gain});

    // stage 5: recombine, add floor and half, round down, saturate
    logic                  q5_valid_reg;
    logic                  q5_in_range_reg;
    logic [40:0]           q5_lo_reg;
    logic signed [PHW-1:0] q5_hi_reg;
    logic signed [TW-1:0]  total;
    logic signed [QW-1:0]  rounded;
    logic signed [QW-1:0]  pre_sat;
    logic signed [QW-1:0]  post_sat;
    result_t               result;

    assign total    = $signed((TW'(q5_hi_reg) <<< 24) + TW'(q5_lo_reg)
                      + (TW'(floor_level_reg) << 32) + (TW'(1) << 31));
    assign rounded  = QW'(total >>> 32);
    assign pre_sat  = q5_in_range_reg ? rounded : $signed(QW'(floor_level_reg));
    assign post_sat = (pre_sat > OMAX) ? OMAX : ((pre_sat < OMIN) ? OMIN : pre_sat);

    assign result.beam_value  = 20'(post_sat);
    assign result.beyond_edge = !q5_in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            q1_valid_reg    <= 1'b0;
            q2_valid_reg    <= 1'b0;
            q3_valid_reg    <= 1'b0;
            q4_valid_reg    <= 1'b0;
            q5_valid_reg    <= 1'b0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
            q1_valid_reg    <= query_acc;
            q2_valid_reg    <= q1_valid_reg;
            q3_valid_reg    <= q2_valid_reg;
            q4_valid_reg    <= q3_valid_reg;
            q5_valid_reg    <= q4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q1_index_reg    <= index_product[56:32];
        q1_invalid_reg  <= in_radius_invalid;
        q2_in_range_reg <= q1_in_range;
        q2_lower_ok_reg <= lower_ok;
        q2_upper_ok_reg <= upper_ok;
        q3_in_range_reg <= q2_in_range_reg;
        q3_pa_reg       <= prod_a;
        q3_pb_reg       <= prod_b;
        q4_in_range_reg <= q3_in_range_reg;
        q4_blend_reg    <= q3_pa_reg + q3_pb_reg;
        q5_in_range_reg <= q4_in_range_reg;
        q5_lo_reg       <= part_lo;
        q5_hi_reg       <= part_hi;
    end

    // result queue: the credit count keeps it from overflowing
    result_t out_item;

    rbtl_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q5_valid_reg),
        .push_data (result),
        .pop       (m_tready),
        .valid     (m_tvalid),
        .data      (out_item)
    );

    assign m_tdata = {4'b0000, out_item.beam_value};
    assign m_tuser = out_item.beyond_edge;

endmodule

// ----- hdl/rbtl_checker.sv -----
module rbtl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    import rbtl_pkg::*;

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;

    // a stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // the floor is never negative, so an edge result is non-negative
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tdata[19])
        else $error("edge result with negative value");

    // with the result queue empty, credits must be left for new items
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with nothing waiting at the output");

    // a floor write reads back on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && (paddr[4:2] == REG_FLOOR_LEVEL)
        |=> (paddr[4:2] != REG_FLOOR_LEVEL) || (prdata[15:0] == $past(pwdata[15:0])))
        else $error("floor register readback mismatch");

endmodule

bind radial_beam_table_lookup_unit rbtl_checker u_rbtl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

// ----- sim/tb_radial_beam_table_lookup_unit.sv -----
module tb_radial_beam_table_lookup_unit;
    import rbtl_pkg::*;

    localparam int SAMPLES     = 1024;
    localparam int TABLES      = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RX_HOLD     = 300;

    class beam_scoreboard;
        logic signed [19:0] entries [TABLES * SAMPLES];
        bit                 written [TABLES * SAMPLES];
        logic [31:0]        scale_q248;
        logic [2:0]         lower_sel;
        logic [2:0]         upper_sel;
        logic [16:0]        weight_q16;
        logic [15:0]        floor_q16;
        result_t            expected_q [$];
        int                 errors;

        function new();
            scale_q248 = '0;
            lower_sel  = '0;
            upper_sel  = '0;
            weight_q16 = '0;
            floor_q16  = FLOOR_RESET;
            errors     = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [31:0] value);
            case (idx)
                REG_INDEX_SCALE:  scale_q248 = value;
                REG_LOWER_TABLE:  lower_sel  = value[2:0];
                REG_UPPER_TABLE:  upper_sel  = value[2:0];
                REG_BLEND_WEIGHT: weight_q16 = value[16:0];
                REG_FLOOR_LEVEL:  floor_q16  = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] sample_index(logic [24:0] radius);
            logic [63:0] prod;
            prod = 64'(radius) * 64'(scale_q248);
            return prod[63:32];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(opcode_t op, logic [2:0] tbl, logic [9:0] smp,
                                logic signed [19:0] val, logic [24:0] radius,
                                logic invalid);
            result_t     res;
            logic [31:0] idx;
            longint      lo_val, up_val, w, f, mix, acc;
            if (op == OP_WRITE)
            begin
                entries[tbl * SAMPLES + smp] = val;
                written[tbl * SAMPLES + smp] = 1'b1;
                return;
            end
            idx = sample_index(radius);
            f = floor_q16;
            if (invalid || idx >= SAMPLES)
            begin
                res.beam_value  = {4'b0, floor_q16};
                res.beyond_edge = 1'b1;
            end
            else
            begin
                lo_val = entries[lower_sel * SAMPLES + idx];
                up_val = entries[upper_sel * SAMPLES + idx];
                w = (weight_q16 > ONE_Q16) ? ONE_Q16 : weight_q16;
                mix = lo_val * (longint'(ONE_Q16) - w) + up_val * w;
                // one rounding, half toward plus infinity
                acc = mix * (longint'(ONE_Q16) - f) + (f <<< 32) + (longint'(1) <<< 31);
                acc = acc >>> 32;
                if (acc > 524287)
                    acc = 524287;
                else if (acc < -524288)
                    acc = -524288;
                res.beam_value  = acc[19:0];
                res.beyond_edge = 1'b0;
            end
            expected_q = {expected_q, res};
        endfunction

        function void check_result(logic signed [19:0] beam, logic beyond);
            result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, beam_value %0d beyond_edge %0b",
                         $time, beam, beyond);
                return;
            end
            want = expected_q.pop_front();
            if (beam !== want.beam_value)
            begin
                errors++;
                $display("%0t: beam_value mismatch, expected %0d, actual %0d",
                         $time, want.beam_value, beam);
            end
            if (beyond !== want.beyond_edge)
            begin
                errors++;
                $display("%0t: beyond_edge mismatch, expected %0b, actual %0b",
                         $time, want.beyond_edge, beyond);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // [2:0] table_number, [12:3] sample_number, [32:13] entry_value,
    // [57:33] radius, [63:58] zero
    logic [63:0] s_tdata;
    // [0] opcode, [1] radius_invalid
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // [19:0] beam_value, [23:20] zero
    logic [23:0] m_tdata;
    // [0] beyond_edge
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    beam_scoreboard sb;
    int             cycle_count;
    int             rx_stall;
    int             hot_sample;
    bit             rx_idle_en;
    bit             tx_idle_en;
    bit             hold_request;

    radial_beam_table_lookup_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [19:0] rand_entry();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 20'h7FFFF;
        else if (r == 1)
            return 20'h80000;
        return 20'($urandom);
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[19:0], m_tuser[0]);
    end

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            rx_stall = RX_HOLD;
        end
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (rx_idle_en && $urandom_range(0, 3) == 0)
                rx_stall = pick_gap();
        end
    end

    // enter and leave on a falling edge
    task automatic send_item(opcode_t op, logic [2:0] tbl, logic [9:0] smp,
                             logic [19:0] val, logic [24:0] radius, logic invalid);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, radius, val, smp, tbl};
        s_tuser  <= {invalid, op};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(op, tbl, smp, val, radius, invalid);
        @(negedge clk);
    endtask

    // give the entries that a query reads a value first
    task automatic send_query(logic [24:0] radius, logic invalid);
        logic [31:0] idx;
        idx = sb.sample_index(radius);
        if (!invalid && idx < SAMPLES)
        begin
            if (!sb.written[sb.lower_sel * SAMPLES + idx])
                send_item(OP_WRITE, sb.lower_sel, 10'(idx), rand_entry(), 25'($urandom),
                          1'($urandom));
            if (!sb.written[sb.upper_sel * SAMPLES + idx])
                send_item(OP_WRITE, sb.upper_sel, 10'(idx), rand_entry(), 25'($urandom),
                          1'($urandom));
        end
        send_item(OP_QUERY, 3'($urandom), 10'($urandom), 20'($urandom), radius, invalid);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // writes leave no result, so allow the pipeline to empty after the last one
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apply_setting(logic [31:0] scale, logic [2:0] lo, logic [2:0] up,
                                 logic [16:0] weight, logic [15:0] flr);
        drain();
        write_reg(REG_INDEX_SCALE, scale);
        write_reg(REG_LOWER_TABLE, 32'(lo));
        write_reg(REG_UPPER_TABLE, 32'(up));
        write_reg(REG_BLEND_WEIGHT, 32'(weight));
        write_reg(REG_FLOOR_LEVEL, 32'(flr));
    endtask

    task automatic random_item();
        logic [24:0] radius;
        logic [9:0]  smp;
        logic [2:0]  tbl;
        logic [31:0] idx;
        logic        invalid;
        if ($urandom_range(0, 99) < 30)
        begin
            if ($urandom_range(0, 1) == 0)
                tbl = $urandom_range(0, 1) ? sb.lower_sel : sb.upper_sel;
            else
                tbl = 3'($urandom);
            // hit the sample just queried to exercise write/read ordering
            smp = $urandom_range(0, 1) ? 10'(hot_sample) : 10'($urandom);
            send_item(OP_WRITE, tbl, smp, rand_entry(), 25'($urandom), 1'($urandom));
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       radius = $urandom_range(0, 1) ? 25'd0 : 25'h100_0000;
                1, 2:    radius = 25'($urandom_range(0, 4095));
                default: radius = 25'($urandom_range(0, 1 << 24));
            endcase
            invalid = ($urandom_range(0, 9) == 0);
            send_query(radius, invalid);
            idx = sb.sample_index(radius);
            if (!invalid && idx < SAMPLES)
                hot_sample = idx;
        end
        if (tx_idle_en && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [31:0] scale;
        logic [16:0] weight;
        logic [15:0] flr;
        sb = new();
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cycle_count  = 0;
        rx_stall     = 0;
        hot_sample   = 0;
        rx_idle_en   = 1'b1;
        tx_idle_en   = 1'b0;
        hold_request = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers still at reset: scale zero maps every radius to sample zero
        send_query(25'h0ABCDE, 1'b0);

        apply_setting(32'h0004_0000, 3'd0, 3'd1, 17'd0, 16'd0);
        send_item(OP_WRITE, 3'd0, 10'd0, 20'h7FFFF, 25'd0, 1'b0);
        send_item(OP_WRITE, 3'd1, 10'd0, 20'h80000, 25'd0, 1'b0);
        send_item(OP_WRITE, 3'd0, 10'd1023, 20'h80000, 25'd0, 1'b0);
        send_item(OP_WRITE, 3'd1, 10'd1023, 20'h7FFFF, 25'd0, 1'b0);
        send_query(25'd0, 1'b0);
        send_query(25'hFF_FFFF, 1'b0);
        send_query(25'h100_0000, 1'b0);
        send_query(25'd0, 1'b1);
        send_query(25'd12345, 1'b1);

        apply_setting(32'h0004_0000, 3'd0, 3'd1, ONE_Q16, 16'hFFFF);
        send_query(25'd0, 1'b0);
        send_query(25'hFF_FFFF, 1'b0);

        // weight above one saturates
        apply_setting(32'hFFFF_FFFF, 3'd7, 3'd7, 17'h1FFFF, FLOOR_RESET);
        send_query(25'd0, 1'b0);
        send_query(25'd1, 1'b0);
        send_query(25'd1024, 1'b0);
        send_query(25'd1025, 1'b0);
        send_query(25'h100_0000, 1'b0);

        // write directly followed by a query of the same entry
        apply_setting(32'd0, 3'd1, 3'd0, 17'd32768, FLOOR_RESET);
        send_item(OP_WRITE, 3'd1, 10'd0, 20'h00003, 25'd0, 1'b0);
        send_query(25'h100_0000, 1'b0);
        send_item(OP_WRITE, 3'd0, 10'd0, 20'hFFFFE, 25'd0, 1'b0);
        send_query(25'd77, 1'b0);

        for (int ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       scale = 32'h0004_0000;
                1:       scale = 32'h0004_0000 + $urandom_range(0, 65535);
                2:       scale = $urandom;
                3:       scale = 32'hFFFF_FFFF;
                4:       scale = 32'd0;
                default: scale = 32'h0002_0000;
            endcase
            case ($urandom_range(0, 4))
                0:       weight = 17'd0;
                1:       weight = ONE_Q16;
                2:       weight = 17'h1FFFF;
                default: weight = 17'($urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 3))
                0:       flr = 16'd0;
                1:       flr = 16'hFFFF;
                2:       flr = FLOOR_RESET;
                default: flr = 16'($urandom);
            endcase
            apply_setting(scale, 3'($urandom), 3'($urandom), weight, flr);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            tx_idle_en = ($urandom_range(0, 3) != 0);
            if (ph == 0)
            begin
                // long receiver hold-off while items keep coming
                tx_idle_en   = 1'b0;
                hold_request = 1'b1;
            end
            repeat (50) random_item();
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
